// ----- src/written_block_bitmap_tracker_core_assert.svh -----
// Assertion macros used by the bitmap tracker checker.
`ifndef WRITTEN_BLOCK_BITMAP_TRACKER_CORE_ASSERT_SVH
`define WRITTEN_BLOCK_BITMAP_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define WBBT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define WBBT_ASSERT_LATER(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, also checked across reset.
`define WBBT_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/wbbt_pkg.sv -----
// Shared types, constants and arithmetic helpers of the bitmap tracker.
package wbbt_pkg;

   localparam int unsigned BITMAP_BITS_DEF = 65536;
   localparam int unsigned IDX_W           = 24;
   localparam int unsigned OFF_W           = 40;
   localparam int unsigned SIZE_W          = 16;
   localparam int unsigned RATIO_W         = 7;
   localparam int unsigned TOTAL_W         = 48;
   localparam int unsigned COUNT_W         = 17;
   localparam int unsigned RATE_W          = 16;
   localparam int unsigned DVD_W           = 48;
   localparam int unsigned DIG_W           = 8;
   localparam int unsigned DIGITS          = DVD_W / DIG_W;
   localparam int unsigned REQ_DATA_W      = 56;
   localparam int unsigned RSP_DATA_W      = 88;
   localparam int unsigned Q_DEPTH         = 2;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [RATE_W-1:0]  RATE_FULL = '1;

   typedef struct packed {
      logic              pad;
      logic              oor;
      logic              empty;
      logic [IDX_W-1:0]  first;
      logic [IDX_W-1:0]  last;
      logic [SIZE_W-1:0] size;
   } work_entry_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIV,
      FR_CEIL,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_WALK,
      BK_DRAIN,
      BK_WAIT,
      BK_PREP,
      BK_RATE,
      BK_OUT
   } back_state_type;

   // One byte of long division by the ratio: returns {remainder, quotient byte}.
   function automatic logic [RATIO_W+DIG_W-1:0] div_digit(
      input logic [RATIO_W-1:0] rem,
      input logic [DIG_W-1:0]   dig,
      input logic [RATIO_W-1:0] d
   );
      logic [RATIO_W:0]   t;
      logic [RATIO_W-1:0] r;
      logic [DIG_W-1:0]   q;
      int                 i;
      r = rem;
      q = '0;
      for (i = DIG_W - 1; i >= 0; i--) begin
         t = {r, dig[i]};
         if (t >= {1'b0, d}) begin
            t    = t - {1'b0, d};
            q[i] = 1'b1;
         end
         r = t[RATIO_W-1:0];
      end
      return {r, q};
   endfunction

endpackage

// ----- src/wbbt_queue.sv -----
// Short work queue between the classifying front end and the bitmap back end.
module wbbt_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  wbbt_pkg::work_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output wbbt_pkg::work_entry_type pop_entry,
   output logic                     empty
);

   localparam int unsigned PW = (wbbt_pkg::Q_DEPTH > 1) ? $clog2(wbbt_pkg::Q_DEPTH) : 1;
   localparam int unsigned CW = $clog2(wbbt_pkg::Q_DEPTH + 1);

   wbbt_pkg::work_entry_type entries_ff [wbbt_pkg::Q_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == CW'(wbbt_pkg::Q_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(wbbt_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(wbbt_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- src/wbbt_front.sv -----
// Front end: accepts write records and turns them into clipped physical block ranges.
module wbbt_front #(
   parameter int unsigned BITMAP_BITS = wbbt_pkg::BITMAP_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [wbbt_pkg::RATIO_W-1:0]        ratio,
   input  logic                                clr_busy,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [wbbt_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   output logic                                push,
   output wbbt_pkg::work_entry_type            push_entry,
   input  logic                                q_full
);

   localparam int unsigned DW  = wbbt_pkg::DVD_W;
   localparam int unsigned GW  = wbbt_pkg::DIG_W;
   localparam int unsigned RW  = wbbt_pkg::RATIO_W;
   localparam int unsigned IW  = wbbt_pkg::IDX_W;
   localparam int unsigned OW  = wbbt_pkg::OFF_W;
   localparam int unsigned SW  = wbbt_pkg::SIZE_W;
   localparam int unsigned CNW = $clog2(wbbt_pkg::DIGITS);

   wbbt_pkg::front_state_type state_ff, state_in;
   logic [DW-1:0]  dvd0_ff, dvd0_in;
   logic [DW-1:0]  dvd1_ff, dvd1_in;
   logic [RW-1:0]  rem0_ff, rem0_in;
   logic [RW-1:0]  rem1_ff, rem1_in;
   logic [SW-1:0]  size_ff, size_in;
   logic           pad_ff, pad_in;
   logic [CNW-1:0] cnt_ff, cnt_in;

   logic [RW+GW-1:0] dig0, dig1;
   logic             oor;
   logic [DW-1:0]    pb1_clip;
   logic [DW-1:0]    last_full;

   assign dig0 = wbbt_pkg::div_digit(rem0_ff, dvd0_ff[DW-1 -: GW], ratio);
   assign dig1 = wbbt_pkg::div_digit(rem1_ff, dvd1_ff[DW-1 -: GW], ratio);

   // Clip the exclusive end to the bitmap and flag the overrun.
   assign oor       = !pad_ff && (dvd1_ff > DW'(BITMAP_BITS));
   assign pb1_clip  = oor ? DW'(BITMAP_BITS) : dvd1_ff;
   assign last_full = pb1_clip - DW'(1);

   always_comb begin
      push_entry.pad   = pad_ff;
      push_entry.oor   = oor;
      push_entry.empty = pad_ff || (dvd0_ff >= pb1_clip);
      push_entry.first = dvd0_ff[IW-1:0];
      push_entry.last  = last_full[IW-1:0];
      push_entry.size  = size_ff;
   end

   always_comb begin
      state_in   = state_ff;
      dvd0_in    = dvd0_ff;
      dvd1_in    = dvd1_ff;
      rem0_in    = rem0_ff;
      rem1_in    = rem1_ff;
      size_in    = size_ff;
      pad_in     = pad_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      push       = 1'b0;
      unique case (state_ff)
         wbbt_pkg::FR_IDLE: begin
            req_tready = !clr_busy;
            if (req_tvalid && !clr_busy) begin
               dvd0_in  = DW'(req_tdata[OW-1:0]);
               dvd1_in  = DW'(req_tdata[OW-1:0]) + DW'(req_tdata[OW+SW-1:OW]);
               rem0_in  = '0;
               rem1_in  = '0;
               size_in  = req_tdata[OW+SW-1:OW];
               pad_in   = req_tuser;
               cnt_in   = CNW'(wbbt_pkg::DIGITS - 1);
               state_in = req_tuser ? wbbt_pkg::FR_PUSH : wbbt_pkg::FR_DIV;
            end
         end
         wbbt_pkg::FR_DIV: begin
            dvd0_in = {dvd0_ff[DW-GW-1:0], dig0[GW-1:0]};
            dvd1_in = {dvd1_ff[DW-GW-1:0], dig1[GW-1:0]};
            rem0_in = dig0[RW+GW-1:GW];
            rem1_in = dig1[RW+GW-1:GW];
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = wbbt_pkg::FR_CEIL;
            end
         end
         wbbt_pkg::FR_CEIL: begin
            dvd1_in  = dvd1_ff + DW'(rem1_ff != '0);
            state_in = wbbt_pkg::FR_PUSH;
         end
         wbbt_pkg::FR_PUSH: begin
            push = !q_full;
            if (!q_full) begin
               state_in = wbbt_pkg::FR_IDLE;
            end
         end
         default: state_in = wbbt_pkg::FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wbbt_pkg::FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd0_ff <= dvd0_in;
      dvd1_ff <= dvd1_in;
      rem0_ff <= rem0_in;
      rem1_ff <= rem1_in;
      size_ff <= size_in;
      pad_ff  <= pad_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ----- src/wbbt_back.sv -----
// Back end: bitmap memory, range marking, running totals, ratio and rate division.
module wbbt_back #(
   parameter int unsigned BITMAP_BITS = wbbt_pkg::BITMAP_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [wbbt_pkg::RATIO_W-1:0]    ratio,
   output logic                            clr_busy,
   input  logic                            q_empty,
   output logic                            q_pop,
   input  wbbt_pkg::work_entry_type        q_entry,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [wbbt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser
);

   localparam int unsigned MAP_WORDS = (BITMAP_BITS + 63) / 64;
   localparam int unsigned WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int unsigned DW        = wbbt_pkg::DVD_W;
   localparam int unsigned GW        = wbbt_pkg::DIG_W;
   localparam int unsigned RW        = wbbt_pkg::RATIO_W;
   localparam int unsigned TW        = wbbt_pkg::TOTAL_W;
   localparam int unsigned CW        = wbbt_pkg::COUNT_W;
   localparam int unsigned QW        = wbbt_pkg::RATE_W;
   localparam int unsigned DCW       = $clog2(wbbt_pkg::DIGITS + 1);
   localparam int unsigned RCW       = $clog2(wbbt_pkg::RATE_W);
   localparam int unsigned PADW      = wbbt_pkg::RSP_DATA_W - TW - CW - QW;

   logic [63:0] map_mem [MAP_WORDS];

   wbbt_pkg::back_state_type state_ff, state_in;
   wbbt_pkg::work_entry_type ent_ff, ent_in;
   logic [WA_W-1:0] clr_addr_ff, clr_addr_in;
   logic [WA_W-1:0] cur_ff, cur_in;
   logic            rd_vld_ff, rd_vld_in;
   logic [WA_W-1:0] rd_word_ff;
   logic [63:0]     rd_data_ff;
   logic [6:0]      pop_ff;
   logic [TW-1:0]   total_ff, total_in;
   logic [CW-1:0]   changed_ff, changed_in;
   logic [DW-1:0]   dvd_ff, dvd_in;
   logic [RW-1:0]   drem_ff, drem_in;
   logic [DCW-1:0]  dcnt_ff, dcnt_in;
   logic [TW-1:0]   written_ff, written_in;
   logic [TW-1:0]   r_ff, r_in;
   logic [QW-1:0]   q_ff, q_in;
   logic [RCW-1:0]  rcnt_ff, rcnt_in;
   logic            rsp_vld_ff, rsp_vld_in;
   logic [wbbt_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic            rsp_oor_ff, rsp_oor_in;

   logic [WA_W-1:0] first_w, last_w;
   logic [WA_W-1:0] q_first_w;
   logic [5:0]      lo, hi;
   logic [63:0]     mask;
   logic [63:0]     new_bits;
   logic            wr_en;
   logic [WA_W-1:0] wr_addr;
   logic [63:0]     wr_data;
   logic [TW:0]     tsum;
   logic [TW-1:0]   total_new;
   logic [CW:0]     csum;
   logic [RW+GW-1:0] dig;
   logic [TW:0]     rs;
   logic [TW:0]     rdiff;

   function automatic logic [6:0] popcnt64(input logic [63:0] v);
      logic [6:0] n;
      int         i;
      n = '0;
      for (i = 0; i < 64; i++) begin
         n = n + 7'(v[i]);
      end
      return n;
   endfunction

   assign clr_busy   = (state_ff == wbbt_pkg::BK_CLEAR);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_oor_ff;

   // Word-level mask for the range edges.
   assign first_w   = ent_ff.first[WA_W+5:6];
   assign last_w    = ent_ff.last[WA_W+5:6];
   assign q_first_w = q_entry.first[WA_W+5:6];
   assign lo        = (rd_word_ff == first_w) ? ent_ff.first[5:0] : 6'd0;
   assign hi        = (rd_word_ff == last_w) ? ent_ff.last[5:0] : 6'd63;
   assign mask      = ({64{1'b1}} << lo) & ({64{1'b1}} >> (6'd63 - hi));
   assign new_bits  = mask & ~rd_data_ff;

   assign wr_en   = clr_busy || rd_vld_ff;
   assign wr_addr = clr_busy ? clr_addr_ff : rd_word_ff;
   assign wr_data = clr_busy ? 64'd0 : (rd_data_ff | mask);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[cur_ff];
   end

   assign tsum      = {1'b0, total_ff} + (TW + 1)'(q_entry.size);
   assign total_new = tsum[TW] ? wbbt_pkg::TOTAL_MAX : tsum[TW-1:0];

   assign csum       = {1'b0, changed_ff} + (CW + 1)'(pop_ff);
   assign changed_in = (csum > (CW + 1)'(wbbt_pkg::COUNT_MAX)) ? wbbt_pkg::COUNT_MAX
                                                                : csum[CW-1:0];

   assign dig   = wbbt_pkg::div_digit(drem_ff, dvd_ff[DW-1 -: GW], ratio);
   assign rs    = {r_ff, 1'b0};
   assign rdiff = rs - {1'b0, written_ff};

   always_comb begin
      state_in    = state_ff;
      ent_in      = ent_ff;
      clr_addr_in = clr_addr_ff;
      cur_in      = cur_ff;
      rd_vld_in   = 1'b0;
      total_in    = total_ff;
      dvd_in      = dvd_ff;
      drem_in     = drem_ff;
      dcnt_in     = dcnt_ff;
      written_in  = written_ff;
      r_in        = r_ff;
      q_in        = q_ff;
      rcnt_in     = rcnt_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_oor_in  = rsp_oor_ff;
      q_pop       = 1'b0;

      // Written-block divider runs alongside the walk.
      if (dcnt_ff != '0) begin
         dvd_in  = {dvd_ff[DW-GW-1:0], dig[GW-1:0]};
         drem_in = dig[RW+GW-1:GW];
         dcnt_in = dcnt_ff - 1'b1;
      end

      unique case (state_ff)
         wbbt_pkg::BK_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == WA_W'(MAP_WORDS - 1)) begin
               state_in = wbbt_pkg::BK_IDLE;
            end
         end
         wbbt_pkg::BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               ent_in   = q_entry;
               if (!q_entry.pad) begin
                  total_in = total_new;
               end
               dvd_in   = q_entry.pad ? DW'(total_ff) : DW'(total_new);
               drem_in  = '0;
               dcnt_in  = DCW'(wbbt_pkg::DIGITS);
               cur_in   = q_first_w;
               state_in = q_entry.empty ? wbbt_pkg::BK_WAIT : wbbt_pkg::BK_WALK;
            end
         end
         wbbt_pkg::BK_WALK: begin
            rd_vld_in = 1'b1;
            if (cur_ff == last_w) begin
               state_in = wbbt_pkg::BK_DRAIN;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         wbbt_pkg::BK_DRAIN: begin
            state_in = wbbt_pkg::BK_WAIT;
         end
         wbbt_pkg::BK_WAIT: begin
            if (dcnt_ff == '0) begin
               written_in = dvd_ff[TW-1:0] + TW'(drem_ff != '0);
               state_in   = wbbt_pkg::BK_PREP;
            end
         end
         wbbt_pkg::BK_PREP: begin
            q_in = '0;
            priority if ((written_ff == '0) || (TW'(changed_ff) > written_ff)) begin
               state_in = wbbt_pkg::BK_OUT;
            end else if (changed_ff == '0) begin
               q_in     = wbbt_pkg::RATE_FULL;
               state_in = wbbt_pkg::BK_OUT;
            end else begin
               r_in     = written_ff - TW'(changed_ff);
               rcnt_in  = RCW'(QW - 1);
               state_in = wbbt_pkg::BK_RATE;
            end
         end
         wbbt_pkg::BK_RATE: begin
            if (rs >= {1'b0, written_ff}) begin
               r_in = rdiff[TW-1:0];
               q_in = {q_ff[QW-2:0], 1'b1};
            end else begin
               r_in = rs[TW-1:0];
               q_in = {q_ff[QW-2:0], 1'b0};
            end
            rcnt_in = rcnt_ff - 1'b1;
            if (rcnt_ff == '0) begin
               state_in = wbbt_pkg::BK_OUT;
            end
         end
         wbbt_pkg::BK_OUT: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {PADW'(0), q_ff, changed_ff, written_ff};
               rsp_oor_in  = ent_ff.oor;
               state_in    = wbbt_pkg::BK_IDLE;
            end
         end
         default: state_in = wbbt_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= wbbt_pkg::BK_CLEAR;
         clr_addr_ff <= '0;
         rd_vld_ff   <= 1'b0;
         pop_ff      <= '0;
         total_ff    <= '0;
         changed_ff  <= '0;
         dcnt_ff     <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         rd_vld_ff   <= rd_vld_in;
         pop_ff      <= rd_vld_ff ? popcnt64(new_bits) : 7'd0;
         total_ff    <= total_in;
         changed_ff  <= changed_in;
         dcnt_ff     <= dcnt_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff      <= ent_in;
      cur_ff      <= cur_in;
      rd_word_ff  <= cur_ff;
      dvd_ff      <= dvd_in;
      drem_ff     <= drem_in;
      written_ff  <= written_in;
      r_ff        <= r_in;
      q_ff        <= q_in;
      rcnt_ff     <= rcnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

endmodule

// ----- src/written_block_bitmap_tracker_core.sv -----
// Top level of the written block bitmap tracker: ratio register, front end, queue, back end.
// Each item passes the front end's division, the queue and the back end's walk of the
// 64-bit words it marks, divider and rate loop; padding skips division and walk, and the
// rate loop is skipped when not needed. The back end takes one item at a time while the
// front end accepts the next. Reset clears totals and the ratio to 1; items wait while the
// bitmap's (BITMAP_BITS + 63) / 64 words (1024 by default) are zeroed, one word a cycle.
module written_block_bitmap_tracker_core #(
   parameter int unsigned BITMAP_BITS = wbbt_pkg::BITMAP_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wbbt_pkg::RATIO_W-1:0]    csr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // offset_lb [39:0], size_lb [55:40]
   input  logic [wbbt_pkg::REQ_DATA_W-1:0] req_tdata,
   // is_padding [0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // written_blocks [47:0], changed_blocks [64:48], overwrite_rate [80:65], zero [87:81]
   output logic [wbbt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // out_of_range [0]
   output logic                            rsp_tuser
);

   logic [wbbt_pkg::RATIO_W-1:0] lbs_ff, lbs_in;
   logic [wbbt_pkg::RATIO_W-1:0] ratio;
   logic                         clr_busy;
   logic                         push;
   logic                         q_full;
   logic                         q_empty;
   logic                         q_pop;
   wbbt_pkg::work_entry_type     push_entry;
   wbbt_pkg::work_entry_type     pop_entry;

   assign csr_ready = 1'b1;
   assign lbs_in    = csr_valid ? csr_data : lbs_ff;
   assign ratio     = (lbs_ff == '0) ? wbbt_pkg::RATIO_W'(1) : lbs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lbs_ff <= wbbt_pkg::RATIO_W'(1);
      end else begin
         lbs_ff <= lbs_in;
      end
   end

   wbbt_front #(
      .BITMAP_BITS (BITMAP_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .ratio      (ratio),
      .clr_busy   (clr_busy),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_entry (push_entry),
      .q_full     (q_full)
   );

   wbbt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   wbbt_back #(
      .BITMAP_BITS (BITMAP_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .ratio      (ratio),
      .clr_busy   (clr_busy),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .q_entry    (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- src/wbbt_checker.sv -----
// Port-level checker of the bitmap tracker and its bind to the top level.
`include "written_block_bitmap_tracker_core_assert.svh"

module wbbt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [wbbt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   `WBBT_ASSERT_ALWAYS(a_reset_quiet, clock, reset, !req_tready && !rsp_tvalid, "busy after reset")
   `WBBT_ASSERT_LATER(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled item changed")
   `WBBT_ASSERT_SAME(a_rate_zero, clock, reset, rsp_tvalid && (rsp_tdata[47:0] == 48'd0), rsp_tdata[80:65] == 16'd0, "rate nonzero with nothing written")
   `WBBT_ASSERT_SAME(a_rate_full, clock, reset, rsp_tvalid && (rsp_tdata[47:0] != 48'd0) && (rsp_tdata[64:48] == 17'd0), rsp_tdata[80:65] == 16'hFFFF, "rate not full with nothing changed")

endmodule

bind written_block_bitmap_tracker_core wbbt_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
